// ===== rtl/char_lcd_4bit_interface_sequencer_assert.svh =====
// Assertion macros shared by the character LCD sequencer RTL
`ifndef CHAR_LCD_4BIT_INTERFACE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_4BIT_INTERFACE_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define CLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CLCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLCD_ASSERT(label, prop, msg)
`define CLCD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/clcd_pkg.sv =====
// Types and constants for the character LCD 4-bit sequencer
`default_nettype none
package clcd_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_INIT    = 3'd1,
    OP_COMMAND = 3'd2,
    OP_DATA    = 3'd3,
    OP_CURSOR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_POWERUP   = 3'd1,
    PH_WAKE_HIGH = 3'd2,
    PH_WAKE_GAP  = 3'd3,
    PH_BYTE_HIGH = 3'd4,
    PH_BYTE_GAP  = 3'd5,
    PH_BYTE_LOW  = 3'd6,
    PH_SETTLE    = 3'd7
  } phase_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWERUP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CTRL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MODE    = 3'd6;

  // init_index: 0 none, 1..4 wake nibbles, 5..9 init commands
  localparam logic [3:0] IDX_NONE       = 4'd0;
  localparam logic [3:0] IDX_WAKE_FIRST = 4'd1;
  localparam logic [3:0] IDX_WAKE_LAST  = 4'd4;
  localparam logic [3:0] IDX_CMD_FIRST  = 4'd5;
  localparam logic [3:0] IDX_CMD_LAST   = 4'd9;
  localparam logic [3:0] IDX_DISPLAY    = 4'd6;
  localparam logic [3:0] IDX_ENTRY      = 4'd7;
  localparam logic [3:0] IDX_CLEAR      = 4'd8;

  localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB = 4'h2;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h80;
  localparam logic [7:0] ROW1_BASE    = 8'h80;
  localparam logic [7:0] ROW2_BASE    = 8'hC0;
  localparam logic [1:0] ROW_FIRST    = 2'd1;
  localparam logic [1:0] ROW_SECOND   = 2'd2;

  typedef struct packed {
    logic [7:0] enable_pulse_ms;
    logic [7:0] settle_ms;
    logic [7:0] powerup_ms;
    logic [7:0] init_step_ms;
    logic [7:0] function_set_word;
    logic [7:0] display_control_word;
    logic [7:0] entry_mode_word;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] wait_count;
    logic [7:0] pending_byte;
    logic [3:0] init_index;
    logic       rs_level;
    logic       en_level;
    logic [3:0] nibble_level;
  } lcd_state_t;

endpackage
`default_nettype wire

// ===== rtl/clcd_step.sv =====
// Next-state logic of the LCD sequencer: applies one tick or request to the state
`default_nettype none
module clcd_step (
  input  clcd_pkg::lcd_state_t st_i,
  input  clcd_pkg::cfg_t       cfg_i,
  input  logic [2:0]           op_i,
  input  logic [7:0]           byte_i,
  input  logic [1:0]           row_i,
  input  logic [5:0]           col_i,
  output clcd_pkg::lcd_state_t st_o,
  output logic                 acc_o
);
  import clcd_pkg::*;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [3:0] idx, input cfg_t c);
    logic [7:0] r;
    case (idx)
      IDX_CMD_FIRST: r = c.function_set_word;
      IDX_DISPLAY:   r = c.display_control_word;
      IDX_ENTRY:     r = c.entry_mode_word;
      IDX_CLEAR:     r = CMD_CLEAR;
      default:       r = CMD_HOME;
    endcase
    return r;
  endfunction

  function automatic lcd_state_t start_byte(input lcd_state_t s, input logic [7:0] b,
                                            input logic rs, input cfg_t c);
    lcd_state_t n;
    n = s;
    n.pending_byte = b;
    n.rs_level     = rs;
    n.nibble_level = b[7:4];
    n.en_level     = 1'b1;
    n.phase        = PH_BYTE_HIGH;
    n.wait_count   = at_least_one(c.enable_pulse_ms);
    return n;
  endfunction

  function automatic lcd_state_t start_wake(input lcd_state_t s, input cfg_t c);
    lcd_state_t n;
    n = s;
    n.nibble_level = (s.init_index < IDX_WAKE_LAST) ? WAKE_NIBBLE : FOUR_BIT_NIB;
    n.en_level     = 1'b1;
    n.phase        = PH_WAKE_HIGH;
    n.wait_count   = at_least_one(c.init_step_ms);
    return n;
  endfunction

  function automatic lcd_state_t byte_done(input lcd_state_t s, input cfg_t c);
    lcd_state_t n;
    logic [3:0] idx;
    n   = s;
    idx = s.init_index + 4'd1;
    if (s.init_index >= IDX_CMD_FIRST && s.init_index < IDX_CMD_LAST) begin
      n.init_index = idx;
      n = start_byte(n, init_cmd(idx, c), 1'b0, c);
    end else begin
      n.init_index = IDX_NONE;
      n.phase      = PH_IDLE;
      n.wait_count = 8'd0;
    end
    return n;
  endfunction

  function automatic lcd_state_t phase_done(input lcd_state_t s, input cfg_t c);
    lcd_state_t n;
    n = s;
    case (s.phase)
      PH_POWERUP: begin
        n.init_index = IDX_WAKE_FIRST;
        n = start_wake(n, c);
      end
      PH_WAKE_HIGH: begin
        n.en_level = 1'b0;
        if (s.init_index < IDX_WAKE_LAST) begin
          n.phase      = PH_WAKE_GAP;
          n.wait_count = at_least_one(c.init_step_ms);
        end else begin
          n.init_index = IDX_CMD_FIRST;
          n = start_byte(n, c.function_set_word, 1'b0, c);
        end
      end
      PH_WAKE_GAP: begin
        n.init_index = s.init_index + 4'd1;
        n = start_wake(n, c);
      end
      PH_BYTE_HIGH: begin
        n.en_level     = 1'b0;
        n.nibble_level = s.pending_byte[3:0];
        n.phase        = PH_BYTE_GAP;
        n.wait_count   = 8'd1;
      end
      PH_BYTE_GAP: begin
        n.en_level   = 1'b1;
        n.phase      = PH_BYTE_LOW;
        n.wait_count = at_least_one(c.enable_pulse_ms);
      end
      PH_BYTE_LOW: begin
        n.en_level = 1'b0;
        if (c.settle_ms == 8'd0) begin
          n = byte_done(n, c);
        end else begin
          n.phase      = PH_SETTLE;
          n.wait_count = c.settle_ms;
        end
      end
      PH_SETTLE: n = byte_done(n, c);
      default: begin
        n.phase      = PH_IDLE;
        n.wait_count = 8'd0;
        n.init_index = IDX_NONE;
      end
    endcase
    return n;
  endfunction

  lcd_state_t tick_st;
  lcd_state_t pwr_st;
  logic [7:0] cursor_addr;
  logic [7:0] wait_dec;
  logic       idle;

  assign idle        = (st_i.phase == PH_IDLE);
  assign wait_dec    = (st_i.wait_count != 8'd0) ? st_i.wait_count - 8'd1 : 8'd0;
  // column is one-based; address wraps at 8 bits
  assign cursor_addr = ((row_i == ROW_FIRST) ? ROW1_BASE : ROW2_BASE)
                       + {2'b00, col_i} - 8'd1;

  always_comb begin
    tick_st = st_i;
    tick_st.wait_count = wait_dec;
    if (wait_dec == 8'd0) begin
      tick_st = phase_done(tick_st, cfg_i);
    end

    pwr_st = st_i;
    pwr_st.rs_level     = 1'b0;
    pwr_st.en_level     = 1'b0;
    pwr_st.nibble_level = 4'd0;
    pwr_st.init_index   = IDX_NONE;
    pwr_st.phase        = PH_POWERUP;
    pwr_st.wait_count   = cfg_i.powerup_ms;
    if (cfg_i.powerup_ms == 8'd0) begin
      pwr_st = phase_done(pwr_st, cfg_i);
    end
  end

  always_comb begin
    st_o  = st_i;
    acc_o = 1'b0;
    case (op_t'(op_i))
      OP_TICK: begin
        if (!idle) st_o = tick_st;
      end
      OP_INIT: begin
        if (idle) begin
          acc_o = 1'b1;
          st_o  = pwr_st;
        end
      end
      OP_COMMAND: begin
        if (idle) begin
          acc_o = 1'b1;
          st_o  = start_byte(st_i, byte_i, 1'b0, cfg_i);
        end
      end
      OP_DATA: begin
        if (idle) begin
          acc_o = 1'b1;
          st_o  = start_byte(st_i, byte_i, 1'b1, cfg_i);
        end
      end
      OP_CURSOR: begin
        if (idle && (row_i == ROW_FIRST || row_i == ROW_SECOND)) begin
          acc_o = 1'b1;
          st_o  = start_byte(st_i, cursor_addr, 1'b0, cfg_i);
        end
      end
      default: begin
        st_o  = st_i;
        acc_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/char_lcd_4bit_interface_sequencer.sv =====
// Top level of the character LCD 4-bit interface sequencer
`default_nettype none
`include "char_lcd_4bit_interface_sequencer_assert.svh"
// Sequencer for a character LCD on a 4-bit bus, timed by 1 ms tick beats.
// Each input beat is a tick or a request (initialise, command byte, data
// byte, set cursor); each gives exactly one output beat with the RS, EN and
// D7..D4 levels after that beat was applied, a busy flag and whether the
// request was taken (requests while busy are refused). One beat is taken per
// clock cycle unless backpressure holds it; a beat passes an input register,
// then the next-state logic, and its result is stored in the output register.
// The output register holds under backpressure while the input register
// still takes one more beat. Configuration registers reset to their
// defaults and should be written only while no beat is in flight.
module char_lcd_4bit_interface_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // byte_value[7:0], cursor_row[9:8], cursor_column[15:10]
  input  logic [2:0]  in_tuser,  // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // register_select[0], enable_strobe[1], data_nibble[5:2], busy_res[6], accepted[7]
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import clcd_pkg::*;

  cfg_t       cfg_r;
  lcd_state_t st_r;
  lcd_state_t st_nxt;
  logic       acc_nxt;

  logic       in_valid_r;
  logic [2:0] in_op_r;
  logic [7:0] in_byte_r;
  logic [1:0] in_row_r;
  logic [5:0] in_col_r;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       advance;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_ms      <= 8'd1;
      cfg_r.settle_ms            <= 8'd5;
      cfg_r.powerup_ms           <= 8'd20;
      cfg_r.init_step_ms         <= 8'd5;
      cfg_r.function_set_word    <= 8'h28;
      cfg_r.display_control_word <= 8'h0C;
      cfg_r.entry_mode_word      <= 8'h06;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE_PULSE: cfg_r.enable_pulse_ms      <= cfg_wdata;
        CFG_SETTLE:       cfg_r.settle_ms            <= cfg_wdata;
        CFG_POWERUP:      cfg_r.powerup_ms           <= cfg_wdata;
        CFG_INIT_STEP:    cfg_r.init_step_ms         <= cfg_wdata;
        CFG_FUNCTION_SET: cfg_r.function_set_word    <= cfg_wdata;
        CFG_DISPLAY_CTRL: cfg_r.display_control_word <= cfg_wdata;
        CFG_ENTRY_MODE:   cfg_r.entry_mode_word      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata[7:0];
      in_row_r  <= in_tdata[9:8];
      in_col_r  <= in_tdata[15:10];
    end
  end

  clcd_step u_step (
    .st_i   (st_r),
    .cfg_i  (cfg_r),
    .op_i   (in_op_r),
    .byte_i (in_byte_r),
    .row_i  (in_row_r),
    .col_i  (in_col_r),
    .st_o   (st_nxt),
    .acc_o  (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= PH_IDLE;
      st_r.wait_count   <= 8'd0;
      st_r.pending_byte <= 8'd0;
      st_r.init_index   <= IDX_NONE;
      st_r.rs_level     <= 1'b0;
      st_r.en_level     <= 1'b0;
      st_r.nibble_level <= 4'd0;
      out_valid_r       <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {acc_nxt, (st_nxt.phase != PH_IDLE), st_nxt.nibble_level,
                     st_nxt.en_level, st_nxt.rs_level};
    end
  end

  // a taken request always leaves the sequencer busy
  `CLCD_ASSERT(a_accept_busy, out_valid_r && out_data_r[7] |-> out_data_r[6], "accepted but not busy")
  `CLCD_ASSERT(a_idle_no_wait, st_r.phase == PH_IDLE |-> st_r.wait_count == 8'd0, "idle with pending wait")
  `CLCD_ASSERT(a_idle_no_init, st_r.phase == PH_IDLE |-> st_r.init_index == IDX_NONE, "idle inside init")
  `CLCD_ASSERT(a_en_phase, st_r.en_level |-> (st_r.phase == PH_WAKE_HIGH || st_r.phase == PH_BYTE_HIGH || st_r.phase == PH_BYTE_LOW), "enable high outside a strobe")
  `CLCD_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid_r && !in_valid_r, "beat valid after reset")

endmodule
`default_nettype wire
